// ===== hw/rtl/roulette_wheel_select_top_macros.svh =====
// Assertion macros for the roulette wheel selection RTL.
`ifndef ROULETTE_WHEEL_SELECT_TOP_MACROS_SVH
`define ROULETTE_WHEEL_SELECT_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("roulette wheel select: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("roulette wheel select: next-cycle check failed");

`endif

// ===== hw/rtl/rws_pkg.sv =====
// Constants shared by the roulette wheel selection block.
`timescale 1ns / 1ps

package rws_pkg;

    localparam int POP_MAX     = 256;
    localparam int WEIGHT_BITS = 16;
    localparam int FRAC_W      = 16;
    localparam int IDX_W       = $clog2(POP_MAX);
    localparam int SIZE_W      = IDX_W + 1;
    localparam int SUM_W       = WEIGHT_BITS + IDX_W;
    localparam int PROD_W      = SUM_W + FRAC_W;

    localparam logic [SIZE_W-1:0] POP_SIZE_RESET = SIZE_W'(100);

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SELECT = 1'b1;

endpackage

// ===== hw/rtl/rws_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module rws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/roulette_wheel_select_top.sv =====
// Top level of the roulette wheel (fitness-proportionate) selection block.
`timescale 1ns / 1ps
`include "roulette_wheel_select_top_macros.svh"

// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_func, s_entry_index, s_weight, s_random_fraction
// m_        out        m_valid / m_ready   m_selected_index
// cfg_      in         cfg_valid/cfg_ready cfg_pop_size
//
// A load item is accepted while the block is idle and written straight into the weight RAM.
// A select holds s_ready low while it sums the weights through the single RAM read port,
// forms the threshold, runs the search, which stops at the chosen entry, and loads the
// result.
// Reset (aresetn, synchronous, active low) clears the control state and sets pop_size
// to 100; the weight RAM is not cleared. A result not yet taken holds the next one back.

module roulette_wheel_select_top (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [rws_pkg::IDX_W-1:0]     s_entry_index,
    input  logic [rws_pkg::WEIGHT_BITS-1:0] s_weight,
    input  logic [rws_pkg::FRAC_W-1:0]    s_random_fraction,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rws_pkg::IDX_W-1:0]     m_selected_index,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rws_pkg::SIZE_W-1:0]    cfg_pop_size
);

    import rws_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t                 state_reg;
    logic [SIZE_W-1:0]      pop_size_reg;
    logic [SIZE_W-1:0]      n_eff;
    logic [IDX_W-1:0]       last_idx;

    logic [FRAC_W-1:0]      frac_reg;
    logic [SUM_W-1:0]       total_reg;
    logic [SUM_W-1:0]       acc_reg;
    logic [SUM_W-1:0]       acc_sum;
    logic [SUM_W-1:0]       thr_reg;
    logic [PROD_W-1:0]      prod;

    logic [SIZE_W-1:0]      issue_cnt_reg;
    logic                   rd_pend_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [IDX_W-1:0]       sel_reg;

    logic                   m_valid_reg;
    logic [IDX_W-1:0]       m_index_reg;

    logic                   s_fire;
    logic                   ram_we;
    logic                   issue_ok;
    logic                   scan_hit;
    logic                   res_load;
    logic [WEIGHT_BITS-1:0] ram_rdata;

    // Effective population size: zero counts as one, anything above the store
    // depth is clamped to it. It governs loads and selects alike.
    always_comb begin
        if (pop_size_reg == '0) begin
            n_eff = SIZE_W'(1);
        end else if (pop_size_reg > SIZE_W'(POP_MAX)) begin
            n_eff = SIZE_W'(POP_MAX);
        end else begin
            n_eff = pop_size_reg;
        end
    end

    assign last_idx = IDX_W'(n_eff - SIZE_W'(1));

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Loads beyond the effective size are dropped.
    assign ram_we = s_fire && (s_func == FUNC_LOAD) && ({1'b0, s_entry_index} < n_eff);

    assign issue_ok = (issue_cnt_reg < n_eff);
    assign acc_sum  = acc_reg + SUM_W'(ram_rdata);
    assign prod     = PROD_W'(frac_reg) * PROD_W'(total_reg);

    // The last entry is chosen when no earlier one reaches the threshold.
    assign scan_hit = (acc_sum >= thr_reg) || (rd_idx_reg == last_idx);

    // The finished result moves into the output register once that is free.
    assign res_load = (state_reg == ST_RESULT) && (!m_valid_reg || m_ready);

    rws_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (POP_MAX)
    ) u_weight_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (s_entry_index),
        .wdata (s_weight),
        .raddr (issue_cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pop_size_reg  <= POP_SIZE_RESET;
            rd_pend_reg   <= 1'b0;
            issue_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                pop_size_reg <= cfg_pop_size;
            end

            if (res_load) begin
                m_valid_reg <= 1'b1;
                m_index_reg <= sel_reg;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    rd_pend_reg <= 1'b0;
                    if (s_fire && (s_func == FUNC_SELECT)) begin
                        frac_reg      <= s_random_fraction;
                        total_reg     <= '0;
                        issue_cnt_reg <= '0;
                        state_reg     <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    // The weight for an address comes back in the cycle after the address goes out.
                    rd_pend_reg <= issue_ok;
                    rd_idx_reg  <= issue_cnt_reg[IDX_W-1:0];
                    if (issue_ok) begin
                        issue_cnt_reg <= issue_cnt_reg + SIZE_W'(1);
                    end
                    if (rd_pend_reg) begin
                        total_reg <= total_reg + SUM_W'(ram_rdata);
                    end
                    if (!issue_ok && !rd_pend_reg) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    // Threshold is r * total in Q0.16, truncated.
                    thr_reg       <= prod[PROD_W-1:FRAC_W];
                    acc_reg       <= '0;
                    issue_cnt_reg <= '0;
                    rd_pend_reg   <= 1'b0;
                    state_reg     <= ST_SCAN;
                end
                ST_SCAN: begin
                    rd_idx_reg <= issue_cnt_reg[IDX_W-1:0];
                    if (issue_ok) begin
                        issue_cnt_reg <= issue_cnt_reg + SIZE_W'(1);
                    end
                    if (rd_pend_reg) begin
                        acc_reg <= acc_sum;
                    end
                    if (rd_pend_reg && scan_hit) begin
                        sel_reg     <= rd_idx_reg;
                        rd_pend_reg <= 1'b0;
                        state_reg   <= ST_RESULT;
                    end else begin
                        rd_pend_reg <= issue_ok;
                    end
                end
                ST_RESULT: begin
                    rd_pend_reg <= 1'b0;
                    if (res_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_selected_index = m_index_reg;

    // No RAM read is in flight while the block is open for a new item.
    `RWS_ASSERT_NOW(a_idle_no_read, aclk, aresetn, s_ready, !rd_pend_reg)
    // Every returned weight belongs to an entry inside the effective size.
    `RWS_ASSERT_NOW(a_read_in_range, aclk, aresetn, rd_pend_reg, ({1'b0, rd_idx_reg} < n_eff))
    // During the search the running sum and the threshold never pass the total.
    `RWS_ASSERT_NOW(a_scan_bounded, aclk, aresetn, (state_reg == ST_SCAN),
                    ((acc_reg <= total_reg) && (thr_reg <= total_reg)))
    // A select leads straight into the summing pass from the first entry.
    `RWS_ASSERT_NEXT(a_select_starts, aclk, aresetn, (s_fire && (s_func == FUNC_SELECT)),
                     ((state_reg == ST_SUM) && (issue_cnt_reg == '0) && (total_reg == '0)))

endmodule
